// ===== sv/cubic_interpolating_resampler_top_assert.svh =====
// Assertion macros for the cubic interpolating resampler.
`ifndef CUBIC_INTERPOLATING_RESAMPLER_TOP_ASSERT_SVH
`define CUBIC_INTERPOLATING_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CIR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cir_pkg.sv =====
// Package: shared types and constants of the cubic interpolating resampler.
package cir_pkg;

   // Phase accumulator and step register width
   localparam int PHASE_BITS = 31;
   // Interpolation fraction t, unsigned Q0.16
   localparam int T_BITS = 16;
   // Most results one input item may cause
   localparam int MAX_RESULTS = 64;
   localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   // Horner step being evaluated
   typedef enum logic [1:0] {
      HS_C,
      HS_B,
      HS_A
   } horner_type;

endpackage

// ===== sv/cubic_interpolating_resampler_top.sv =====
// Catmull-Rom cubic resampler: one shared multiplier driven by a small sequencer.
//
// Fractional-rate resampler. Each input item (req_) first releases the
// interpolated outputs (rsp_) owed while the phase is below one, then enters
// the four-sample history. rsp_last marks the final output caused by an item;
// an item may cause none. At most 64 outputs per item. csr_step sets input
// samples advanced per output (FRAC_BITS fraction bits) and is to be written
// only while the block is idle; the block itself does not enforce this. Each
// output runs three Horner steps on one shared multiplier of about half the
// operand width by 17 bits; each step passes through a low half, a high half
// and an accumulate state, then an emit state rounds, saturates and emits.
// The input is not ready while an item is at work.
module cubic_interpolating_resampler_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_last,
   // step register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cir_pkg::PHASE_BITS-1:0] csr_step
);

   // Datapath widths
   localparam int OPND_W = SAMPLE_BITS + 23;       // Horner operand
   localparam int LO_W   = (OPND_W + 1) / 2;       // low half of operand
   localparam int HI_W   = OPND_W - LO_W;          // high half of operand
   localparam int MA_W   = LO_W + 1;               // multiplier operand
   localparam int PROD_W = MA_W + cir_pkg::T_BITS + 1;
   localparam int TOT_W  = PROD_W + LO_W;
   localparam int CA_W   = SAMPLE_BITS + 1;        // coefficient a
   localparam int CB_W   = SAMPLE_BITS + 5;        // coefficient b
   localparam int CC_W   = SAMPLE_BITS + 4;        // coefficient c
   localparam int Y_W    = OPND_W + 1 - 17;        // rounded sample before clamp
   localparam int PX_W   = cir_pkg::PHASE_BITS + 17;

   localparam logic [32:0] ONE_W = 33'd1 << FRAC_BITS;
   localparam logic [cir_pkg::PHASE_BITS-1:0] ONE_P = ONE_W[cir_pkg::PHASE_BITS-1:0];
   localparam logic signed [Y_W-1:0] Y_MAX = {{(Y_W-SAMPLE_BITS+1){1'b0}},
                                              {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [Y_W-1:0] Y_MIN = {{(Y_W-SAMPLE_BITS+1){1'b1}},
                                              {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [cir_pkg::CNT_BITS-1:0] CNT_MAX =
      cir_pkg::CNT_BITS'(cir_pkg::MAX_RESULTS);

   // State
   cir_pkg::state_type  state_ff, state_in;
   cir_pkg::horner_type hstep_ff, hstep_in;
   logic [cir_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [cir_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [cir_pkg::PHASE_BITS-1:0] step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] hist_ff [4];
   logic signed [SAMPLE_BITS-1:0] hist_in [4];
   logic signed [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic signed [CA_W-1:0] ca_ff, ca_in;
   logic signed [CB_W-1:0] cb_ff, cb_in;
   logic signed [CC_W-1:0] cc_ff, cc_in;
   logic [cir_pkg::T_BITS-1:0] t_ff, t_in;
   logic signed [OPND_W-1:0] opnd_ff, opnd_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_last_ff, rsp_last_in;

   // Helpers
   logic req_fire;
   logic out_free;
   logic phase_lt_one;
   logic emit_go;
   logic [PX_W-1:0] phase_x;
   logic signed [MA_W-1:0] mul_a;
   logic signed [TOT_W-1:0] total;
   logic signed [OPND_W-1:0] hres;
   logic [cir_pkg::PHASE_BITS:0] phase_sum;
   logic [cir_pkg::PHASE_BITS-1:0] phase_adv;
   logic adv_lt_one;
   logic [cir_pkg::CNT_BITS-1:0] cnt_inc;
   logic signed [OPND_W:0] ysum;
   logic signed [Y_W-1:0] yval;
   logic signed [SAMPLE_BITS-1:0] ysat;
   logic signed [SAMPLE_BITS+3:0] h0x, h1x, h2x, h3x;

   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign phase_lt_one = {2'b00, phase_ff} < ONE_W;
   assign emit_go      = (state_ff == cir_pkg::ST_EMIT) && out_free;
   assign phase_x      = {17'd0, phase_ff};

   // Ports
   assign req_ready      = (state_ff == cir_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;

   // Shared multiplier: one operand half times t
   always_comb begin
      if (state_ff == cir_pkg::ST_MUL_LO) begin
         mul_a = $signed({1'b0, opnd_ff[LO_W-1:0]});
      end else begin
         mul_a = $signed({{(MA_W-HI_W){opnd_ff[OPND_W-1]}}, opnd_ff[OPND_W-1:LO_W]});
      end
   end
   assign prod_in = mul_a * $signed({1'b0, t_ff});

   // Recombine halves; floor divide by 2^16 after the first step
   assign total = $signed({{(TOT_W-PROD_W){acc_ff[PROD_W-1]}}, acc_ff})
                + $signed({prod_ff, {LO_W{1'b0}}});
   assign hres  = (hstep_ff == cir_pkg::HS_C) ? total[OPND_W-1:0]
                                              : total[OPND_W+15:16];

   // Phase advance, saturating at full scale
   assign phase_sum  = {1'b0, phase_ff} + {1'b0, step_ff};
   assign phase_adv  = phase_sum[cir_pkg::PHASE_BITS] ? {cir_pkg::PHASE_BITS{1'b1}}
                                                      : phase_sum[cir_pkg::PHASE_BITS-1:0];
   assign adv_lt_one = {2'b00, phase_adv} < ONE_W;
   assign cnt_inc    = cnt_ff + 1'b1;

   // Final rounding (halve, round half up) and clamp
   assign ysum = $signed({{(OPND_W-SAMPLE_BITS-16){hist_ff[1][SAMPLE_BITS-1]}},
                          hist_ff[1], 17'd0})
               + $signed({opnd_ff[OPND_W-1], opnd_ff})
               + $signed({{(OPND_W-16){1'b0}}, 1'b1, 16'd0});
   assign yval = ysum[OPND_W:17];
   always_comb begin
      if (yval > Y_MAX) begin
         ysat = Y_MAX[SAMPLE_BITS-1:0];
      end else if (yval < Y_MIN) begin
         ysat = Y_MIN[SAMPLE_BITS-1:0];
      end else begin
         ysat = yval[SAMPLE_BITS-1:0];
      end
   end

   // Coefficients from the current history
   assign h0x = {{4{hist_ff[0][SAMPLE_BITS-1]}}, hist_ff[0]};
   assign h1x = {{4{hist_ff[1][SAMPLE_BITS-1]}}, hist_ff[1]};
   assign h2x = {{4{hist_ff[2][SAMPLE_BITS-1]}}, hist_ff[2]};
   assign h3x = {{4{hist_ff[3][SAMPLE_BITS-1]}}, hist_ff[3]};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cir_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = cir_pkg::ST_CHECK;
            end
         end
         cir_pkg::ST_CHECK: begin
            if (phase_lt_one && (cnt_ff < CNT_MAX)) begin
               state_in = cir_pkg::ST_MUL_LO;
            end else begin
               state_in = cir_pkg::ST_IDLE;
            end
         end
         cir_pkg::ST_MUL_LO: state_in = cir_pkg::ST_MUL_HI;
         cir_pkg::ST_MUL_HI: state_in = cir_pkg::ST_ACCUM;
         cir_pkg::ST_ACCUM: begin
            if (hstep_ff == cir_pkg::HS_A) begin
               state_in = cir_pkg::ST_EMIT;
            end else begin
               state_in = cir_pkg::ST_MUL_LO;
            end
         end
         cir_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = cir_pkg::ST_CHECK;
            end
         end
         default: state_in = cir_pkg::ST_IDLE;
      endcase
   end

   // Datapath and control outputs
   always_comb begin
      hstep_in      = hstep_ff;
      cnt_in        = cnt_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      hist_in       = hist_ff;
      smp_in        = smp_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      cc_in         = cc_ff;
      t_in          = t_ff;
      opnd_in       = opnd_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         step_in = csr_step;
      end

      unique case (state_ff)
         cir_pkg::ST_IDLE: begin
            if (req_fire) begin
               smp_in = req_sample_in;
               ca_in  = CA_W'(h2x - h0x);
               cb_in  = CB_W'((h0x <<< 1) - (h1x <<< 2) - h1x + (h2x <<< 2) - h3x);
               cc_in  = CC_W'((h1x <<< 1) + h1x - (h2x <<< 1) - h2x + h3x - h0x);
               cnt_in = '0;
            end
         end
         cir_pkg::ST_CHECK: begin
            if (phase_lt_one && (cnt_ff < CNT_MAX)) begin
               t_in     = phase_x[FRAC_BITS-1 -: cir_pkg::T_BITS];
               opnd_in  = OPND_W'(cc_ff);
               hstep_in = cir_pkg::HS_C;
            end else begin
               // item done: shift history, drop one sample of phase (zero if below one)
               hist_in[0] = hist_ff[1];
               hist_in[1] = hist_ff[2];
               hist_in[2] = hist_ff[3];
               hist_in[3] = smp_ff;
               phase_in   = phase_lt_one ? '0 : (phase_ff - ONE_P);
               cnt_in     = '0;
            end
         end
         cir_pkg::ST_MUL_LO: begin
         end
         cir_pkg::ST_MUL_HI: begin
            acc_in = prod_ff;
         end
         cir_pkg::ST_ACCUM: begin
            case (hstep_ff)
               cir_pkg::HS_C: begin
                  opnd_in  = hres + $signed({{(OPND_W-CB_W-16){cb_ff[CB_W-1]}}, cb_ff, 16'd0});
                  hstep_in = cir_pkg::HS_B;
               end
               cir_pkg::HS_B: begin
                  opnd_in  = hres + $signed({{(OPND_W-CA_W-16){ca_ff[CA_W-1]}}, ca_ff, 16'd0});
                  hstep_in = cir_pkg::HS_A;
               end
               default: begin
                  opnd_in = hres;
               end
            endcase
         end
         cir_pkg::ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = ysat;
               rsp_last_in   = !(adv_lt_one && (cnt_inc < CNT_MAX));
               phase_in      = phase_adv;
               cnt_in        = cnt_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cir_pkg::ST_IDLE;
         hstep_ff     <= cir_pkg::HS_C;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         step_ff      <= ONE_P;
         hist_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hstep_ff     <= hstep_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      smp_ff        <= smp_in;
      ca_ff         <= ca_in;
      cb_ff         <= cb_in;
      cc_ff         <= cc_in;
      t_ff          <= t_in;
      opnd_ff       <= opnd_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Checks
`include "cubic_interpolating_resampler_top_assert.svh"

   `CIR_ASSERT_SAME(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_MAX, "result count past cap")
   `CIR_ASSERT_NEXT(a_cap_ends, clock, reset, (state_ff == cir_pkg::ST_CHECK) && (cnt_ff == CNT_MAX), state_ff == cir_pkg::ST_IDLE, "cap reached but item not closed")
   `CIR_ASSERT_SAME(a_ready_clean, clock, reset, req_ready, cnt_ff == '0, "ready with results pending")
   `CIR_ASSERT_NEXT(a_emit_loads, clock, reset, emit_go, rsp_valid_ff, "emitted result not presented")

endmodule
